@@ rtl/alarm_beeper_pulse_controller_core_macros.svh @@
// Assertion macros for the alarm beeper pulse controller.
// The including module must have the signals clk and rst in scope.
`ifndef ALARM_BEEPER_PULSE_CONTROLLER_CORE_MACROS_SVH
`define ALARM_BEEPER_PULSE_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ABPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abpc assertion failed");

`endif

@@ rtl/abpc_pkg.sv @@
// Package for the alarm beeper pulse controller.
// Holds command and mode codes, register indexes and reset values; no dependencies.
`default_nettype none

package abpc_pkg;

  localparam int ERROR_BITS_DEF = 15;
  localparam int TIMER_BITS_DEF = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TICKS_W     = 16;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET       = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_CLEAR_ALL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_CONT  = 2'd1,
    MODE_SHORT = 2'd2,
    MODE_LONG  = 2'd3
  } mode_t;

  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_MASK          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_MASK      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFLICT_MASK      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_ON_TICKS     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PERIOD_TICKS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_ON_TICKS      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PERIOD_TICKS  = 3'd6;

  localparam logic [CFG_DATA_W-1:0] TEMP_MASK_RST          = 16'd7168;
  localparam logic [CFG_DATA_W-1:0] FEEDBACK_MASK_RST      = 16'd1022;
  localparam logic [CFG_DATA_W-1:0] CONFLICT_MASK_RST      = 16'd24577;
  localparam logic [TICKS_W-1:0]    SHORT_ON_TICKS_RST     = 16'd50;
  localparam logic [TICKS_W-1:0]    SHORT_PERIOD_TICKS_RST = 16'd100;
  localparam logic [TICKS_W-1:0]    LONG_ON_TICKS_RST      = 16'd1000;
  localparam logic [TICKS_W-1:0]    LONG_PERIOD_TICKS_RST  = 16'd2000;

endpackage

`default_nettype wire

@@ rtl/alarm_beeper_pulse_controller_core.sv @@
// Alarm beeper pulse controller: error bitmap, beep mode choice and pulse timer.
// Depends on abpc_pkg and alarm_beeper_pulse_controller_core_macros.svh.
//
// Usage: each input transfer carries a command (tick, set flags, clear flags,
// clear all) and an error bitmap. Every input transfer yields exactly one
// output transfer with the alarm, beeper, mode and flag state after the item.
// The state registers are the output register, so a result is presented in
// the cycle after its input transfer. One item is taken per cycle
// (throughput 1), limited only by the single output register: a new input is
// taken in the same cycle in which the pending result is transferred.
// When the receiver stalls, in_stall rises in the same cycle and the result
// holds until transferred. The configuration channel is always ready; its
// writes take effect at once. The user must make them only while the block is
// idle; the block does not enforce it. Reset restores the register defaults,
// clears flags, mode, beeper and elapsed counter; no result is left pending.
`default_nettype none
`include "alarm_beeper_pulse_controller_core_macros.svh"

module alarm_beeper_pulse_controller_core #(
  parameter int ERROR_BITS = abpc_pkg::ERROR_BITS_DEF,
  parameter int TIMER_BITS = abpc_pkg::TIMER_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      command,
  input  wire logic [ERROR_BITS-1:0]           error_bits,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 alarm_on,
  output logic                                 beeper_on,
  output logic [1:0]                           sound_mode,
  output logic [ERROR_BITS-1:0]                flags_now,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [abpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [abpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (TIMER_BITS > abpc_pkg::TICKS_W) ? TIMER_BITS : abpc_pkg::TICKS_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [ERROR_BITS-1:0]             temp_mask;
  logic [ERROR_BITS-1:0]             feedback_mask;
  logic [ERROR_BITS-1:0]             conflict_mask;
  logic [abpc_pkg::TICKS_W-1:0]      short_on_ticks;
  logic [abpc_pkg::TICKS_W-1:0]      short_period_ticks;
  logic [abpc_pkg::TICKS_W-1:0]      long_on_ticks;
  logic [abpc_pkg::TICKS_W-1:0]      long_period_ticks;

  logic [ERROR_BITS-1:0]             error_map;
  logic [ERROR_BITS-1:0]             error_map_next;
  abpc_pkg::mode_t                   mode;
  abpc_pkg::mode_t                   mode_next;
  abpc_pkg::mode_t                   mode_pick;
  logic                              beeping;
  logic                              beeping_next;
  logic [TIMER_BITS-1:0]             elapsed;
  logic [TIMER_BITS-1:0]             elapsed_next;
  logic [TIMER_BITS-1:0]             elapsed_inc;
  logic [CMP_W-1:0]                  elapsed_cmp;
  logic [CMP_W-1:0]                  on_cmp;
  logic [CMP_W-1:0]                  period_cmp;
  logic                              alarm;
  abpc_pkg::cmd_t                    cmd;
  logic                              in_xfer;

  assign in_stall  = out_valid & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cmd       = abpc_pkg::cmd_t'(command);

  assign alarm_on   = alarm;
  assign beeper_on  = beeping;
  assign sound_mode = mode;
  assign flags_now  = error_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_mask          <= abpc_pkg::TEMP_MASK_RST[ERROR_BITS-1:0];
      feedback_mask      <= abpc_pkg::FEEDBACK_MASK_RST[ERROR_BITS-1:0];
      conflict_mask      <= abpc_pkg::CONFLICT_MASK_RST[ERROR_BITS-1:0];
      short_on_ticks     <= abpc_pkg::SHORT_ON_TICKS_RST;
      short_period_ticks <= abpc_pkg::SHORT_PERIOD_TICKS_RST;
      long_on_ticks      <= abpc_pkg::LONG_ON_TICKS_RST;
      long_period_ticks  <= abpc_pkg::LONG_PERIOD_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abpc_pkg::REG_TEMP_MASK:          temp_mask          <= cfg_data[ERROR_BITS-1:0];
        abpc_pkg::REG_FEEDBACK_MASK:      feedback_mask      <= cfg_data[ERROR_BITS-1:0];
        abpc_pkg::REG_CONFLICT_MASK:      conflict_mask      <= cfg_data[ERROR_BITS-1:0];
        abpc_pkg::REG_SHORT_ON_TICKS:     short_on_ticks     <= cfg_data;
        abpc_pkg::REG_SHORT_PERIOD_TICKS: short_period_ticks <= cfg_data;
        abpc_pkg::REG_LONG_ON_TICKS:      long_on_ticks      <= cfg_data;
        abpc_pkg::REG_LONG_PERIOD_TICKS:  long_period_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Mode choice by priority; flags that match no mask keep the current mode.
  always_comb begin
    mode_pick = mode;
    if (error_map_next == '0) begin
      mode_pick = abpc_pkg::MODE_OFF;
    end else if ((error_map_next & temp_mask) != '0) begin
      mode_pick = abpc_pkg::MODE_CONT;
    end else if ((error_map_next & feedback_mask) != '0) begin
      mode_pick = abpc_pkg::MODE_SHORT;
    end else if ((error_map_next & conflict_mask) != '0) begin
      mode_pick = abpc_pkg::MODE_LONG;
    end
  end

  assign elapsed_inc = (elapsed != TIMER_MAX) ? elapsed + 1'b1 : elapsed;
  assign elapsed_cmp = CMP_W'(elapsed_inc);
  assign on_cmp      = (mode == abpc_pkg::MODE_LONG) ? CMP_W'(long_on_ticks)
                                                     : CMP_W'(short_on_ticks);
  assign period_cmp  = (mode == abpc_pkg::MODE_LONG) ? CMP_W'(long_period_ticks)
                                                     : CMP_W'(short_period_ticks);

  always_comb begin
    error_map_next = error_map;
    mode_next      = mode;
    beeping_next   = beeping;
    elapsed_next   = elapsed;
    case (cmd)
      abpc_pkg::CMD_TICK: begin
        elapsed_next = elapsed_inc;
        case (mode)
          abpc_pkg::MODE_CONT: begin
            beeping_next = 1'b1;
          end
          abpc_pkg::MODE_SHORT, abpc_pkg::MODE_LONG: begin
            if (elapsed_cmp < on_cmp) begin
              beeping_next = 1'b1;
            end else if (elapsed_cmp < period_cmp) begin
              beeping_next = 1'b0;
            end else begin
              elapsed_next = '0;
              beeping_next = 1'b1;
            end
          end
          default: begin
            beeping_next = 1'b0;
          end
        endcase
      end
      abpc_pkg::CMD_SET, abpc_pkg::CMD_CLEAR: begin
        if (cmd == abpc_pkg::CMD_SET) begin
          error_map_next = error_map | error_bits;
        end else begin
          error_map_next = error_map & ~error_bits;
        end
        if (mode_pick != mode) begin
          mode_next    = mode_pick;
          elapsed_next = '0;
          beeping_next = 1'b0;
        end
      end
      default: begin
        error_map_next = '0;
        mode_next      = abpc_pkg::MODE_OFF;
        beeping_next   = 1'b0;
        elapsed_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_map <= '0;
      mode      <= abpc_pkg::MODE_OFF;
      beeping   <= 1'b0;
      elapsed   <= '0;
      alarm     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        error_map <= error_map_next;
        mode      <= mode_next;
        beeping   <= beeping_next;
        elapsed   <= elapsed_next;
        alarm     <= (error_map_next != '0);
      end
      if (in_xfer) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ABPC_ASSERT_SAME(a_alarm_matches_flags, out_valid, alarm_on == (flags_now != '0))
  `ABPC_ASSERT_SAME(a_no_flags_mode_off, out_valid && (flags_now == '0), sound_mode == abpc_pkg::MODE_OFF)
  `ABPC_ASSERT_SAME(a_off_mode_silent, out_valid && (sound_mode == abpc_pkg::MODE_OFF), !beeper_on)
  `ABPC_ASSERT_NEXT(a_clear_all_resets, in_xfer && (cmd == abpc_pkg::CMD_CLEAR_ALL), (elapsed == '0) && (flags_now == '0) && !beeper_on)
  `ABPC_ASSERT_NEXT(a_cont_tick_sounds, in_xfer && (cmd == abpc_pkg::CMD_TICK) && (mode == abpc_pkg::MODE_CONT), beeper_on)

endmodule

`default_nettype wire
